@@ hdl/lbei_pkg.sv @@
// ---------------------------------------------------------------------------
// lbei_pkg
// shared widths, register indexes and types for the line/box edge
// intersection pipeline
// ---------------------------------------------------------------------------
package lbei_pkg;

    localparam int COORD_W    = 32;   // Q16.16 coordinate
    localparam int TOL_W      = 17;   // tolerance registers
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = DIFF_W + COORD_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int NUM_W      = 65;   // 2*|c1| + |v|
    localparam int DEN_W      = COORD_W + 1;   // 2*|v|
    localparam int QUO_W      = 34;   // rounded offset along the edge
    localparam int DIV_STAGES = QUO_W;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_EDGES  = 4;

    // edge order: left, top, right, bottom
    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_TOP    = 1;
    localparam int EDGE_RIGHT  = 2;
    localparam int EDGE_BOTTOM = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_MIN_X   = 3'd0,
        CFG_BOX_MIN_Y   = 3'd1,
        CFG_BOX_MAX_X   = 3'd2,
        CFG_BOX_MAX_Y   = 3'd3,
        CFG_ZERO_TOL    = 3'd4,
        CFG_MATCH_TOL   = 3'd5
    } t_cfg_idx;

    // per-query data that rides alongside the dividers
    typedef struct packed {
        logic [NUM_EDGES-1:0]      hit;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
    } t_side;

endpackage

@@ hdl/line_box_edge_intersections.sv @@
// ---------------------------------------------------------------------------
// line_box_edge_intersections
// intersects the line through (origin, origin+dir) with the four sides of a
// configured axis-aligned box and reports up to two distinct hit points
// ---------------------------------------------------------------------------
// usage:
//  - input channel (i_in_valid / o_in_stall) carries origin and direction;
//    a transaction happens on a rising edge with valid high and stall low
//  - output channel (o_out_valid / i_out_stall) carries the flags and the
//    two ordered points, one result transaction per input transaction
//  - config channel (i_cfg_valid / o_cfg_ready) writes box bounds and the
//    two tolerances; it is always ready and is meant to be used only while
//    the pipeline is empty
//  - throughput: one query per clock while the output is not stalled;
//    depth: 6 front stages, 34 divider stages, 6 back stages; the
//    divider, one quotient bit per stage, sets depth
//  - reset clears every stage valid bit and loads the default box
//    (0,0)-(1,1) with both tolerances at one lsb
//  - a stall on the output freezes the whole pipeline in place, and the
//    input channel is stalled in the same cycle; nothing is dropped
// ---------------------------------------------------------------------------
module line_box_edge_intersections import lbei_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // query channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [COORD_W-1:0] i_origin_x,
    input  logic signed [COORD_W-1:0] i_origin_y,
    input  logic signed [COORD_W-1:0] i_dir_x,
    input  logic signed [COORD_W-1:0] i_dir_y,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_hit_found,
    output logic                      o_second_found,
    output logic                      o_extra_found,
    output logic signed [COORD_W-1:0] o_first_x,
    output logic signed [COORD_W-1:0] o_first_y,
    output logic signed [COORD_W-1:0] o_second_x,
    output logic signed [COORD_W-1:0] o_second_y,
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [COORD_W-1:0]        i_cfg_data
);

    // ------------------------------------------------------------------
    // same-point test, per coordinate: gap within the match tolerance
    // ------------------------------------------------------------------
    function automatic logic near(input logic signed [COORD_W-1:0] a,
                                  input logic signed [COORD_W-1:0] b,
                                  input logic [TOL_W-1:0] tol);
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        m;
        d = DIFF_W'(a) - DIFF_W'(b);
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return m <= DIFF_W'(tol);
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] r_box_min_x, r_box_min_y, r_box_max_x, r_box_max_y;
    logic [TOL_W-1:0]          r_zero_tol, r_match_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min_x <= '0;
            r_box_min_y <= '0;
            r_box_max_x <= 32'sd65536;
            r_box_max_y <= 32'sd65536;
            r_zero_tol  <= TOL_W'(1);
            r_match_tol <= TOL_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BOX_MIN_X: r_box_min_x <= i_cfg_data;
                CFG_BOX_MIN_Y: r_box_min_y <= i_cfg_data;
                CFG_BOX_MAX_X: r_box_max_x <= i_cfg_data;
                CFG_BOX_MAX_Y: r_box_max_y <= i_cfg_data;
                CFG_ZERO_TOL:  r_zero_tol  <= i_cfg_data[TOL_W-1:0];
                CFG_MATCH_TOL: r_match_tol <= i_cfg_data[TOL_W-1:0];
                default: ;  // unmapped index, write is dropped
            endcase
        end
    end

    // box extents; left/right edges run along y, top/bottom along x
    logic signed [DIFF_W-1:0] w_dxb, w_dyb;
    assign w_dxb = DIFF_W'(r_box_max_x) - DIFF_W'(r_box_min_x);
    assign w_dyb = DIFF_W'(r_box_max_y) - DIFF_W'(r_box_min_y);

    // ------------------------------------------------------------------
    // global advance: the whole pipe holds while a result is stalled
    // ------------------------------------------------------------------
    logic w_en;
    logic r_l_valid;

    assign w_en       = !(r_l_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // ------------------------------------------------------------------
    // stage A: capture the query
    // ------------------------------------------------------------------
    logic                      r_a_valid;
    logic signed [COORD_W-1:0] r_a_px, r_a_py, r_a_vx, r_a_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_px <= i_origin_x;
            r_a_py <= i_origin_y;
            r_a_vx <= i_dir_x;
            r_a_vy <= i_dir_y;
        end
    end

    // ------------------------------------------------------------------
    // stage B: corner offsets from the origin
    // ------------------------------------------------------------------
    logic                      r_b_valid;
    logic signed [DIFF_W-1:0]  r_b_ax0, r_b_ax1, r_b_ay0, r_b_ay1;
    logic signed [COORD_W-1:0] r_b_px, r_b_py, r_b_vx, r_b_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_ax0 <= DIFF_W'(r_box_min_x) - DIFF_W'(r_a_px);
            r_b_ax1 <= DIFF_W'(r_box_max_x) - DIFF_W'(r_a_px);
            r_b_ay0 <= DIFF_W'(r_box_min_y) - DIFF_W'(r_a_py);
            r_b_ay1 <= DIFF_W'(r_box_max_y) - DIFF_W'(r_a_py);
            r_b_px  <= r_a_px;
            r_b_py  <= r_a_py;
            r_b_vx  <= r_a_vx;
            r_b_vy  <= r_a_vy;
        end
    end

    // ------------------------------------------------------------------
    // stage C: products for the cross terms and the direction length
    // ------------------------------------------------------------------
    logic                         r_c_valid;
    logic signed [PROD_W-1:0]     r_c_ax0vy, r_c_ax1vy, r_c_ay0vx, r_c_ay1vx;
    logic signed [PROD_W-1:0]     r_c_p, r_c_q;
    logic signed [2*COORD_W-1:0]  r_c_vx2, r_c_vy2;
    logic signed [COORD_W-1:0]    r_c_px, r_c_py, r_c_vx, r_c_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_ax0vy <= PROD_W'(r_b_ax0) * PROD_W'(r_b_vy);
            r_c_ax1vy <= PROD_W'(r_b_ax1) * PROD_W'(r_b_vy);
            r_c_ay0vx <= PROD_W'(r_b_ay0) * PROD_W'(r_b_vx);
            r_c_ay1vx <= PROD_W'(r_b_ay1) * PROD_W'(r_b_vx);
            // edge denominators: left = p, top = -q, right = -p, bottom = q
            r_c_p     <= PROD_W'(r_b_vx) * PROD_W'(w_dyb);
            r_c_q     <= PROD_W'(r_b_vy) * PROD_W'(w_dxb);
            r_c_vx2   <= (2*COORD_W)'(r_b_vx) * (2*COORD_W)'(r_b_vx);
            r_c_vy2   <= (2*COORD_W)'(r_b_vy) * (2*COORD_W)'(r_b_vy);
            r_c_px    <= r_b_px;
            r_c_py    <= r_b_py;
            r_c_vx    <= r_b_vx;
            r_c_vy    <= r_b_vy;
        end
    end

    // ------------------------------------------------------------------
    // stage D: edge numerators, length test, |v|
    // ------------------------------------------------------------------
    logic                      r_d_valid;
    logic signed [CROSS_W-1:0] r_d_c1 [NUM_EDGES];
    logic signed [PROD_W-1:0]  r_d_p, r_d_q;
    logic                      r_d_len_ok;
    logic [COORD_W-1:0]        r_d_avx, r_d_avy;
    logic signed [COORD_W-1:0] r_d_px, r_d_py, r_d_vx, r_d_vy;

    logic [2*COORD_W-1:0]      w_len2;
    logic [2*TOL_W-1:0]        w_tol2;

    assign w_len2 = (2*COORD_W)'(r_c_vx2) + (2*COORD_W)'(r_c_vy2);
    assign w_tol2 = (2*TOL_W)'(r_zero_tol) * (2*TOL_W)'(r_zero_tol);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_c1[EDGE_LEFT]   <= CROSS_W'(r_c_ax0vy) - CROSS_W'(r_c_ay0vx);
            r_d_c1[EDGE_TOP]    <= CROSS_W'(r_c_ax0vy) - CROSS_W'(r_c_ay1vx);
            r_d_c1[EDGE_RIGHT]  <= CROSS_W'(r_c_ax1vy) - CROSS_W'(r_c_ay1vx);
            r_d_c1[EDGE_BOTTOM] <= CROSS_W'(r_c_ax1vy) - CROSS_W'(r_c_ay0vx);
            r_d_p      <= r_c_p;
            r_d_q      <= r_c_q;
            r_d_len_ok <= w_len2 > (2*COORD_W)'(w_tol2);
            r_d_avx    <= r_c_vx[COORD_W-1] ? COORD_W'(-r_c_vx) : COORD_W'(r_c_vx);
            r_d_avy    <= r_c_vy[COORD_W-1] ? COORD_W'(-r_c_vy) : COORD_W'(r_c_vy);
            r_d_px     <= r_c_px;
            r_d_py     <= r_c_py;
            r_d_vx     <= r_c_vx;
            r_d_vy     <= r_c_vy;
        end
    end

    // ------------------------------------------------------------------
    // stage E: magnitudes and signs
    // ------------------------------------------------------------------
    logic                        r_e_valid;
    logic [CROSS_W-1:0]          r_e_c1abs [NUM_EDGES];
    logic [NUM_EDGES-1:0]        r_e_c1neg, r_e_c1zero;
    logic [2*COORD_W-1:0]        r_e_pabs, r_e_qabs;
    logic                        r_e_pneg, r_e_qneg, r_e_len_ok;
    logic [COORD_W-1:0]          r_e_avx, r_e_avy;
    logic signed [COORD_W-1:0]   r_e_px, r_e_py, r_e_vx, r_e_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NUM_EDGES; k++) begin
                r_e_c1abs[k]  <= r_d_c1[k][CROSS_W-1] ? CROSS_W'(-r_d_c1[k])
                                                      : CROSS_W'(r_d_c1[k]);
                r_e_c1neg[k]  <= r_d_c1[k][CROSS_W-1];
                r_e_c1zero[k] <= r_d_c1[k] == '0;
            end
            r_e_pabs   <= r_d_p[PROD_W-1] ? (2*COORD_W)'(-r_d_p) : (2*COORD_W)'(r_d_p);
            r_e_qabs   <= r_d_q[PROD_W-1] ? (2*COORD_W)'(-r_d_q) : (2*COORD_W)'(r_d_q);
            r_e_pneg   <= r_d_p[PROD_W-1];
            r_e_qneg   <= r_d_q[PROD_W-1];
            r_e_len_ok <= r_d_len_ok;
            r_e_avx    <= r_d_avx;
            r_e_avy    <= r_d_avy;
            r_e_px     <= r_d_px;
            r_e_py     <= r_d_py;
            r_e_vx     <= r_d_vx;
            r_e_vy     <= r_d_vy;
        end
    end

    // ------------------------------------------------------------------
    // stage F: hit test per edge and divider operands
    //   offset = round(|c1| / |v_along|), since c2 = v_along * edge length
    // ------------------------------------------------------------------
    logic                 r_f_valid;
    logic [NUM_W-1:0]     r_f_num [NUM_EDGES];
    logic [DEN_W-1:0]     r_f_den [NUM_EDGES];
    t_side                r_f_side;

    logic [2*COORD_W-1:0] w_c2abs [NUM_EDGES];
    logic [NUM_EDGES-1:0] w_c2neg;
    logic [COORD_W-1:0]   w_vabs  [NUM_EDGES];
    logic [NUM_EDGES-1:0] w_hit;
    logic [2*COORD_W-1:0] w_zthr;

    assign w_zthr = (2*COORD_W)'({r_zero_tol, 16'b0});

    always_comb begin
        w_c2abs[EDGE_LEFT]   = r_e_pabs;
        w_c2abs[EDGE_TOP]    = r_e_qabs;
        w_c2abs[EDGE_RIGHT]  = r_e_pabs;
        w_c2abs[EDGE_BOTTOM] = r_e_qabs;
        w_c2neg[EDGE_LEFT]   = r_e_pneg;
        w_c2neg[EDGE_TOP]    = !r_e_qneg;
        w_c2neg[EDGE_RIGHT]  = !r_e_pneg;
        w_c2neg[EDGE_BOTTOM] = r_e_qneg;
        w_vabs[EDGE_LEFT]    = r_e_avx;
        w_vabs[EDGE_TOP]     = r_e_avy;
        w_vabs[EDGE_RIGHT]   = r_e_avx;
        w_vabs[EDGE_BOTTOM]  = r_e_avy;
        for (int k = 0; k < NUM_EDGES; k++) begin
            // c2 sign is meaningful only once |c2| clears the threshold
            w_hit[k] = r_e_len_ok && (w_c2abs[k] > w_zthr) &&
                       (r_e_c1zero[k] ||
                        ((r_e_c1neg[k] == w_c2neg[k]) &&
                         (r_e_c1abs[k] <= CROSS_W'(w_c2abs[k]))));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NUM_EDGES; k++) begin
                r_f_num[k] <= NUM_W'({r_e_c1abs[k], 1'b0}) + NUM_W'(w_vabs[k]);
                r_f_den[k] <= {w_vabs[k], 1'b0};
            end
            r_f_side.hit <= w_hit;
            r_f_side.px  <= r_e_px;
            r_f_side.py  <= r_e_py;
            r_f_side.vx  <= r_e_vx;
            r_f_side.vy  <= r_e_vy;
        end
    end

    // ------------------------------------------------------------------
    // four dividers with the query data delayed alongside
    // ------------------------------------------------------------------
    logic [QUO_W-1:0] w_quo [NUM_EDGES];

    for (genvar k = 0; k < NUM_EDGES; k++) begin : g_div
        lbei_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_f_num[k]),
            .i_den (r_f_den[k]),
            .o_quo (w_quo[k])
        );
    end

    logic                  r_s_valid [DIV_STAGES];
    t_side                 r_s_side  [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_side[0] <= r_f_side;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_s_side[s] <= r_s_side[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage G: hit points; the fixed coordinate is the edge line itself
    // ------------------------------------------------------------------
    logic                      r_g_valid;
    logic signed [COORD_W-1:0] r_g_hx [NUM_EDGES];
    logic signed [COORD_W-1:0] r_g_hy [NUM_EDGES];
    t_side                     r_g_side;

    logic [COORD_W-1:0] w_q [NUM_EDGES];

    always_comb begin
        for (int k = 0; k < NUM_EDGES; k++) begin
            w_q[k] = w_quo[k][COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_hx[EDGE_LEFT]   <= r_box_min_x;
            r_g_hy[EDGE_LEFT]   <= r_box_min_y +
                (w_dyb[DIFF_W-1] ? COORD_W'(-w_q[EDGE_LEFT]) : w_q[EDGE_LEFT]);
            r_g_hy[EDGE_TOP]    <= r_box_max_y;
            r_g_hx[EDGE_TOP]    <= r_box_min_x +
                (w_dxb[DIFF_W-1] ? COORD_W'(-w_q[EDGE_TOP]) : w_q[EDGE_TOP]);
            // right and bottom run against the box extent
            r_g_hx[EDGE_RIGHT]  <= r_box_max_x;
            r_g_hy[EDGE_RIGHT]  <= r_box_max_y +
                (w_dyb > 0 ? COORD_W'(-w_q[EDGE_RIGHT]) : w_q[EDGE_RIGHT]);
            r_g_hy[EDGE_BOTTOM] <= r_box_min_y;
            r_g_hx[EDGE_BOTTOM] <= r_box_max_x +
                (w_dxb > 0 ? COORD_W'(-w_q[EDGE_BOTTOM]) : w_q[EDGE_BOTTOM]);
            r_g_side <= r_s_side[DIV_STAGES-1];
        end
    end

    // ------------------------------------------------------------------
    // stage H: pairwise same-point matrix
    // ------------------------------------------------------------------
    logic                      r_h_valid;
    logic [NUM_EDGES-1:0]      r_h_match [NUM_EDGES];
    logic signed [COORD_W-1:0] r_h_hx [NUM_EDGES];
    logic signed [COORD_W-1:0] r_h_hy [NUM_EDGES];
    t_side                     r_h_side;

    logic [NUM_EDGES-1:0]      w_match [NUM_EDGES];

    always_comb begin
        for (int i = 0; i < NUM_EDGES; i++) begin
            w_match[i] = '0;
        end
        for (int i = 0; i < NUM_EDGES; i++) begin
            for (int j = i + 1; j < NUM_EDGES; j++) begin
                w_match[i][j] = near(r_g_hx[i], r_g_hx[j], r_match_tol) &&
                                near(r_g_hy[i], r_g_hy[j], r_match_tol);
                w_match[j][i] = w_match[i][j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NUM_EDGES; k++) begin
                r_h_match[k] <= w_match[k];
                r_h_hx[k]    <= r_g_hx[k];
                r_h_hy[k]    <= r_g_hy[k];
            end
            r_h_side <= r_g_side;
        end
    end

    // ------------------------------------------------------------------
    // stage I: walk the edges in order, keep first and second distinct hit
    // ------------------------------------------------------------------
    logic                      r_i_valid;
    logic                      r_i_hit, r_i_second, r_i_extra;
    logic signed [COORD_W-1:0] r_i_p1x, r_i_p1y, r_i_p2x, r_i_p2y;
    logic signed [COORD_W-1:0] r_i_px, r_i_py, r_i_vx, r_i_vy;

    logic       w_hit1, w_hit2, w_extra;
    logic [1:0] w_i1, w_i2;

    always_comb begin
        w_hit1  = 1'b0;
        w_hit2  = 1'b0;
        w_extra = 1'b0;
        w_i1    = '0;
        w_i2    = '0;
        for (int k = 0; k < NUM_EDGES; k++) begin
            if (r_h_side.hit[k]) begin
                if (!w_hit1) begin
                    w_hit1 = 1'b1;
                    w_i1   = 2'(k);
                end else if (r_h_match[w_i1][k]) begin
                    // duplicate of point one, dropped
                end else if (!w_hit2) begin
                    w_hit2 = 1'b1;
                    w_i2   = 2'(k);
                end else if (!r_h_match[w_i2][k]) begin
                    w_extra = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_hit    <= w_hit1;
            r_i_second <= w_hit2;
            r_i_extra  <= w_extra;
            r_i_p1x    <= w_hit1 ? r_h_hx[w_i1] : '0;
            r_i_p1y    <= w_hit1 ? r_h_hy[w_i1] : '0;
            r_i_p2x    <= w_hit2 ? r_h_hx[w_i2] : '0;
            r_i_p2y    <= w_hit2 ? r_h_hy[w_i2] : '0;
            r_i_px     <= r_h_side.px;
            r_i_py     <= r_h_side.py;
            r_i_vx     <= r_h_side.vx;
            r_i_vy     <= r_h_side.vy;
        end
    end

    // ------------------------------------------------------------------
    // stage J: point two relative to the origin
    // ------------------------------------------------------------------
    logic                      r_j_valid;
    logic                      r_j_hit, r_j_second, r_j_extra;
    logic signed [COORD_W-1:0] r_j_p1x, r_j_p1y, r_j_p2x, r_j_p2y;
    logic signed [DIFF_W-1:0]  r_j_dx, r_j_dy;
    logic signed [COORD_W-1:0] r_j_vx, r_j_vy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j_hit    <= r_i_hit;
            r_j_second <= r_i_second;
            r_j_extra  <= r_i_extra;
            r_j_p1x    <= r_i_p1x;
            r_j_p1y    <= r_i_p1y;
            r_j_p2x    <= r_i_p2x;
            r_j_p2y    <= r_i_p2y;
            r_j_dx     <= DIFF_W'(r_i_p2x) - DIFF_W'(r_i_px);
            r_j_dy     <= DIFF_W'(r_i_p2y) - DIFF_W'(r_i_py);
            r_j_vx     <= r_i_vx;
            r_j_vy     <= r_i_vy;
        end
    end

    // ------------------------------------------------------------------
    // stage K: dot product terms
    // ------------------------------------------------------------------
    logic                      r_k_valid;
    logic                      r_k_hit, r_k_second, r_k_extra;
    logic signed [COORD_W-1:0] r_k_p1x, r_k_p1y, r_k_p2x, r_k_p2y;
    logic signed [PROD_W-1:0]  r_k_mx, r_k_my;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k_hit    <= r_j_hit;
            r_k_second <= r_j_second;
            r_k_extra  <= r_j_extra;
            r_k_p1x    <= r_j_p1x;
            r_k_p1y    <= r_j_p1y;
            r_k_p2x    <= r_j_p2x;
            r_k_p2y    <= r_j_p2y;
            r_k_mx     <= PROD_W'(r_j_vx) * PROD_W'(r_j_dx);
            r_k_my     <= PROD_W'(r_j_vy) * PROD_W'(r_j_dy);
        end
    end

    // ------------------------------------------------------------------
    // stage L: order the points and hold the result transaction
    //   point two ahead along the direction swaps the pair
    // ------------------------------------------------------------------
    logic                      r_l_hit, r_l_second, r_l_extra;
    logic signed [COORD_W-1:0] r_l_p1x, r_l_p1y, r_l_p2x, r_l_p2y;

    logic signed [CROSS_W-1:0] w_dot;
    logic                      w_swap;

    assign w_dot  = CROSS_W'(r_k_mx) + CROSS_W'(r_k_my);
    assign w_swap = r_k_second && !w_dot[CROSS_W-1] && (w_dot != '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l_hit    <= r_k_hit;
            r_l_second <= r_k_second;
            r_l_extra  <= r_k_extra;
            r_l_p1x    <= w_swap ? r_k_p2x : r_k_p1x;
            r_l_p1y    <= w_swap ? r_k_p2y : r_k_p1y;
            r_l_p2x    <= w_swap ? r_k_p1x : r_k_p2x;
            r_l_p2y    <= w_swap ? r_k_p1y : r_k_p2y;
        end
    end

    // ------------------------------------------------------------------
    // valid bits travel with the data
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_s_valid[s] <= 1'b0;
            end
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_i_valid <= 1'b0;
            r_j_valid <= 1'b0;
            r_k_valid <= 1'b0;
            r_l_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid    <= i_in_valid;
            r_b_valid    <= r_a_valid;
            r_c_valid    <= r_b_valid;
            r_d_valid    <= r_c_valid;
            r_e_valid    <= r_d_valid;
            r_f_valid    <= r_e_valid;
            r_s_valid[0] <= r_f_valid;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_s_valid[s] <= r_s_valid[s-1];
            end
            r_g_valid <= r_s_valid[DIV_STAGES-1];
            r_h_valid <= r_g_valid;
            r_i_valid <= r_h_valid;
            r_j_valid <= r_i_valid;
            r_k_valid <= r_j_valid;
            r_l_valid <= r_k_valid;
        end
    end

    // ------------------------------------------------------------------
    // result ports
    // ------------------------------------------------------------------
    assign o_out_valid    = r_l_valid;
    assign o_hit_found    = r_l_hit;
    assign o_second_found = r_l_second;
    assign o_extra_found  = r_l_extra;
    assign o_first_x      = r_l_p1x;
    assign o_first_y      = r_l_p1y;
    assign o_second_x     = r_l_p2x;
    assign o_second_y     = r_l_p2y;

endmodule

@@ hdl/lbei_div.sv @@
// ---------------------------------------------------------------------------
// lbei_div
// pipelined restoring divider, one quotient bit per stage; quotient must
// fit QUO_W bits
// ---------------------------------------------------------------------------
module lbei_div import lbei_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    localparam int HI_W = NUM_W - QUO_W;

    logic [DEN_W-1:0] r_rem [DIV_STAGES-1];
    logic [DEN_W-1:0] r_den [DIV_STAGES-1];
    logic [QUO_W-1:0] r_low [DIV_STAGES-1];
    logic [QUO_W-1:0] r_quo [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] low_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] n_rem;

        if (s == 0) begin : g_first
            assign rem_in = {{(DEN_W-HI_W){1'b0}}, i_num[NUM_W-1 -: HI_W]};
            assign den_in = i_den;
            assign low_in = i_num[QUO_W-1:0];
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign low_in = r_low[s-1];
            assign quo_in = r_quo[s-1];
        end

        assign trial = {rem_in, low_in[QUO_W-1]};
        assign ge    = trial >= {1'b0, den_in};
        assign n_rem = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s] <= {quo_in[QUO_W-2:0], ge};
            end
        end

        if (s < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_den[s] <= den_in;
                    r_low[s] <= {low_in[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

@@ sim/line_box_edge_intersections_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_box_edge_intersections_tb
// checks the line/box edge intersection pipeline against a cycle-free
// predictor: directed corner and edge cases, then randomized queries over
// several box and tolerance settings with random input gaps and output
// stalls, then a backpressure test
module line_box_edge_intersections_tb;
    import lbei_pkg::*;

    localparam int  HALF_PERIOD = 4;
    localparam int  LATENCY     = 45;
    localparam int  IDLE_LIMIT  = 5000;
    localparam int  MAX_SHOWN   = 10;
    localparam longint ONE      = 65536;

    typedef struct packed {
        bit                        hit;
        bit                        second;
        bit                        extra;
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
    } t_isect;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [COORD_W-1:0] i_origin_x = '0;
    logic signed [COORD_W-1:0] i_origin_y = '0;
    logic signed [COORD_W-1:0] i_dir_x = '0;
    logic signed [COORD_W-1:0] i_dir_y = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic                      o_hit_found;
    logic                      o_second_found;
    logic                      o_extra_found;
    logic signed [COORD_W-1:0] o_first_x;
    logic signed [COORD_W-1:0] o_first_y;
    logic signed [COORD_W-1:0] o_second_x;
    logic signed [COORD_W-1:0] o_second_y;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [COORD_W-1:0]        i_cfg_data = '0;

    // predictor copy of the configuration, tracks the reset values
    logic signed [COORD_W-1:0] box_x0 = 0;
    logic signed [COORD_W-1:0] box_y0 = 0;
    logic signed [COORD_W-1:0] box_x1 = 32'sd65536;
    logic signed [COORD_W-1:0] box_y1 = 32'sd65536;
    logic [TOL_W-1:0]          zero_tol = 1;
    logic [TOL_W-1:0]          match_tol = 1;

    t_isect pending_isect[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     hold_cycles = 0;   // receiver hold-off, counted down at negedge
    bit     calm = 1'b0;       // no random idling on either side

    line_box_edge_intersections i_dut (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    // round(c1 * d / c2), ties away from zero; caller ensures |c1| <= |c2|
    function automatic longint edge_offset(logic signed [127:0] c1,
                                           logic signed [127:0] c2, longint d);
        logic [127:0] a1, a2, md, num, quo;
        bit           neg;
        a1  = (c1 < 0) ? -c1 : c1;
        a2  = (c2 < 0) ? -c2 : c2;
        md  = (d < 0) ? -d : d;
        neg = ((c1 < 0) != (c2 < 0)) ^ (d < 0);
        num = ((a1 * md) << 1) + a2;
        quo = num / (a2 << 1);
        return neg ? -longint'(quo[33:0]) : longint'(quo[33:0]);
    endfunction

    function automatic bit edge_cross(longint px, longint py, longint vx, longint vy,
                                      longint e1x, longint e1y, longint e2x,
                                      longint e2y, output longint hx, output longint hy);
        logic signed [127:0] rx, ry, wx, wy, ddx, ddy, c1, c2, a1, a2, lim;
        rx  = e1x - px;
        ry  = e1y - py;
        wx  = vx;
        wy  = vy;
        ddx = e2x - e1x;
        ddy = e2y - e1y;
        c1  = rx * wy - ry * wx;
        c2  = wx * ddy - wy * ddx;
        a2  = (c2 < 0) ? -c2 : c2;
        lim = zero_tol;
        lim = lim << 16;
        hx  = 0;
        hy  = 0;
        // parallel or nearly parallel edge
        if (a2 <= lim) return 1'b0;
        if (c1 != 0) begin
            if ((c1 < 0) != (c2 < 0)) return 1'b0;
            a1 = (c1 < 0) ? -c1 : c1;
            if (a1 > a2) return 1'b0;
        end
        hx = e1x + edge_offset(c1, c2, e2x - e1x);
        hy = e1y + edge_offset(c1, c2, e2y - e1y);
        return 1'b1;
    endfunction

    function automatic bit near_point(longint ax, longint ay, longint bx, longint by);
        longint ddx, ddy;
        ddx = (ax > bx) ? ax - bx : bx - ax;
        ddy = (ay > by) ? ay - by : by - ay;
        return ddx <= longint'(match_tol) && ddy <= longint'(match_tol);
    endfunction

    function automatic t_isect predict_isect(logic signed [COORD_W-1:0] ox,
                                             logic signed [COORD_W-1:0] oy,
                                             logic signed [COORD_W-1:0] dx,
                                             logic signed [COORD_W-1:0] dy);
        longint              ex[5], ey[5];
        longint              px, py, vx, vy, hx, hy, p1x, p1y, p2x, p2y, tmp;
        logic signed [127:0] wx, wy, len2, tol2, dot, tx, ty;
        bit                  hit, second, extra;
        t_isect              r;
        px = ox; py = oy; vx = dx; vy = dy;
        // edges left, top, right, bottom as a closed corner walk
        ex[0] = box_x0; ey[0] = box_y0;
        ex[1] = box_x0; ey[1] = box_y1;
        ex[2] = box_x1; ey[2] = box_y1;
        ex[3] = box_x1; ey[3] = box_y0;
        ex[4] = box_x0; ey[4] = box_y0;
        p1x = 0; p1y = 0; p2x = 0; p2y = 0;
        hit = 0; second = 0; extra = 0;
        wx   = vx;
        wy   = vy;
        len2 = wx * wx + wy * wy;
        tol2 = zero_tol;
        tol2 = tol2 * tol2;
        if (len2 > tol2) begin
            for (int k = 0; k < NUM_EDGES; k++) begin
                if (!edge_cross(px, py, vx, vy, ex[k], ey[k], ex[k+1], ey[k+1], hx, hy))
                    continue;
                if (!hit) begin
                    hit = 1; p1x = hx; p1y = hy;
                end else if (near_point(p1x, p1y, hx, hy)) begin
                    continue;
                end else if (!second) begin
                    second = 1; p2x = hx; p2y = hy;
                end else if (!near_point(p2x, p2y, hx, hy)) begin
                    extra = 1;
                end
            end
        end
        // order the pair so point two lies behind along the direction
        if (second) begin
            tx  = p2x - px;
            ty  = p2y - py;
            dot = wx * tx + wy * ty;
            if (dot > 0) begin
                tmp = p1x; p1x = p2x; p2x = tmp;
                tmp = p1y; p1y = p2y; p2y = tmp;
            end
        end
        r.hit = hit; r.second = second; r.extra = extra;
        r.fx = p1x[31:0]; r.fy = p1y[31:0]; r.sx = p2x[31:0]; r.sy = p2y[31:0];
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // transaction monitor: predicts on accepted queries, checks results
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_isect want;
        t_isect seen;
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (i_in_valid && !o_in_stall)
                pending_isect.push_back(predict_isect(i_origin_x, i_origin_y,
                                                      i_dir_x, i_dir_y));
            if (o_out_valid && !i_out_stall) begin
                seen.hit = o_hit_found; seen.second = o_second_found;
                seen.extra = o_extra_found;
                seen.fx = o_first_x; seen.fy = o_first_y;
                seen.sx = o_second_x; seen.sy = o_second_y;
                if (pending_isect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("ERROR: result transaction with no query pending");
                end else begin
                    want = pending_isect.pop_front();
                    if (want !== seen) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display({"ERROR: mismatch exp hit=%0b sec=%0b ext=%0b ",
                                      "p1=(%0d,%0d) p2=(%0d,%0d) got hit=%0b sec=%0b ",
                                      "ext=%0b p1=(%0d,%0d) p2=(%0d,%0d)"},
                                     want.hit, want.second, want.extra, want.fx,
                                     want.fy, want.sx, want.sy, seen.hit, seen.second,
                                     seen.extra, seen.fx, seen.fy, seen.sx, seen.sy);
                    end
                end
            end
        end
    end

    // watchdog: too long without any transaction
    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver side: hold-off first, then random stalls unless calm
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 20);
        end
    end

    // ---------------------------------------------------------------------
    // shared driver tasks, always entered and left at a falling edge
    // ---------------------------------------------------------------------
    task automatic send_query(logic signed [31:0] ox, logic signed [31:0] oy,
                              logic signed [31:0] dx, logic signed [31:0] dy);
        if (!calm && $urandom_range(99) < 20) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_origin_x = ox;
        i_origin_y = oy;
        i_dir_x    = dx;
        i_dir_y    = dy;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        @(negedge i_clk);
    endtask

    // stop offering and wait until every query has come back
    task automatic drain_queries();
        i_in_valid = 1'b0;
        while (pending_isect.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            CFG_BOX_MIN_X: box_x0    = value;
            CFG_BOX_MIN_Y: box_y0    = value;
            CFG_BOX_MAX_X: box_x1    = value;
            CFG_BOX_MAX_Y: box_y1    = value;
            CFG_ZERO_TOL:  zero_tol  = value[TOL_W-1:0];
            CFG_MATCH_TOL: match_tol = value[TOL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_box(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                           logic [31:0] y1, logic [31:0] ztol, logic [31:0] mtol);
        drain_queries();
        write_reg(CFG_BOX_MIN_X, x0);
        write_reg(CFG_BOX_MIN_Y, y0);
        write_reg(CFG_BOX_MAX_X, x1);
        write_reg(CFG_BOX_MAX_Y, y1);
        write_reg(CFG_ZERO_TOL, ztol);
        write_reg(CFG_MATCH_TOL, mtol);
    endtask

    // random coordinate near the box span on one axis
    function automatic logic signed [31:0] near_span(logic signed [31:0] a,
                                                     logic signed [31:0] b);
        longint lo, hi, v;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        v  = lo + longint'($urandom) % (hi - lo + 1);
        if ($urandom_range(3) == 0)
            v += longint'($signed($urandom)) >>> $urandom_range(8, 30);
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] rand_dir();
        return $signed($urandom) >>> $urandom_range(0, 24);
    endfunction

    // mostly lines through the box, then axis lines, corner lines and noise
    task automatic send_random_query();
        logic signed [31:0] ox, oy, dx, dy;
        int                 kind;
        kind = $urandom_range(9);
        ox = near_span(box_x0, box_x1);
        oy = near_span(box_y0, box_y1);
        dx = rand_dir();
        dy = rand_dir();
        if (kind == 6) begin
            if ($urandom_range(1)) dx = 0; else dy = 0;
        end else if (kind == 7) begin
            ox = $urandom_range(1) ? box_x0 : box_x1;
            oy = $urandom_range(1) ? box_y0 : box_y1;
            if ($urandom_range(1)) dy = $urandom_range(1) ? dx : -dx;
        end else if (kind >= 8) begin
            ox = $urandom; oy = $urandom; dx = $urandom; dy = $urandom;
        end
        send_query(ox, oy, dx, dy);
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------
    task automatic test_directed();
        // default unit box straight after reset
        send_query(0, ONE / 2, ONE, 0);             // horizontal, two hits
        send_query(ONE, ONE / 2, -ONE, 0);          // same line, reversed order
        send_query(ONE / 2, 0, 0, ONE);             // vertical
        send_query(0, 0, ONE, ONE);                 // diagonal through two corners
        send_query(0, ONE, ONE, ONE);               // touches one corner only
        send_query(ONE / 4, ONE / 4, 0, 0);         // zero direction
        send_query(0, 0, 1, 0);                     // direction at the tolerance
        send_query(0, 2 * ONE, ONE, 0);             // misses the box
        send_query(0, 0, 0, ONE);                   // along the left edge
        send_query(ONE / 3, ONE / 3, 3, 7);         // tiny direction, rounding
        send_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_query(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_query(0, 0, 32'sh80000000, 32'sh7fffffff);
        send_query(32'sh7fffffff, 32'sh80000000, 1, -1);
        send_query(-ONE, -ONE, -1, -1);
        // zero matching distance: nearly-corner lines may give three hits
        set_box(0, 0, 3, 3, 0, 0);
        send_query(0, 1, 3, 1);
        send_query(1, 0, 1, 1);
        send_query(0, 0, 2, 3);
        send_query(-1, 3, 1, -1);
        // inverted box
        set_box(ONE, ONE, 0, 0, 1, 1);
        send_query(0, ONE / 2, ONE, 0);
        send_query(0, 0, ONE, ONE);
    endtask

    task automatic run_random(int count);
        repeat (count) send_random_query();
    endtask

    task automatic test_random_settings();
        set_box(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 0);
        run_random(160);
        set_box(0, 0, ONE, ONE, 1, 1);
        run_random(160);
        set_box(-100 * ONE, -50 * ONE, 100 * ONE, 50 * ONE, 65536, 65536);
        run_random(160);
        set_box(5 * ONE, 7 * ONE, -3 * ONE, -2 * ONE, $urandom_range(65536),
                $urandom_range(65536));
        run_random(160);
        set_box(2 * ONE, -ONE, 2 * ONE, ONE, 1, 1);  // zero-width box
        run_random(160);
        set_box(-3, -3, 3, 3, 32'h1ffff, 32'h1ffff);
        run_random(160);
        set_box($urandom, $urandom, $urandom, $urandom, $urandom_range(32'h1ffff),
                $urandom_range(32'h1ffff));
        run_random(160);
        // long stretch with no idling on either side
        calm = 1'b1;
        set_box(-ONE, -ONE, ONE, ONE, 0, 2);
        run_random(160);
        calm = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, filling the pipe
    task automatic test_backpressure();
        set_box(-10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE, 1, 1);
        calm = 1'b1;
        hold_cycles = 300;
        run_random(120);
        calm = 1'b0;
        run_random(130);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_settings();
        test_backpressure();
        drain_queries();
        repeat (LATENCY + 10) @(negedge i_clk);
        if (mismatches == 0 && pending_isect.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
